// File: rtl/core/ztr_pkg.sv
// Package: shared types, constants and helpers for the zone trigger tracker.
package ztr_pkg;

    localparam int MAX_CONTEXTS = 8;
    localparam int CNT_W        = $clog2(MAX_CONTEXTS + 1);
    localparam int DUR_W        = 20;

    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_DETECT = 2'd1;
    localparam logic [1:0] ACT_STOP   = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    localparam logic [1:0] EV_TRIGGERED = 2'd0;
    localparam logic [1:0] EV_STOPPED   = 2'd1;
    localparam logic [1:0] EV_FULL      = 2'd2;

    localparam logic [2:0] STOP_ACTION  = 3'd0;
    localparam logic [2:0] STOP_TIMEOUT = 3'd1;

    localparam logic [1:0] HIT_SECOND = 2'd2;
    localparam logic [1:0] HIT_MAX    = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_POST,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic [15:0]      zone;
        logic             blind;
        logic [DUR_W-1:0] hold;
        logic [DUR_W-1:0] prev;
        logic [DUR_W-1:0] elapsed;
        logic [15:0]      blind_left;
        logic [1:0]       hits;
        logic [15:0]      max_dur;
        logic [15:0]      augment;
    } t_entry;

    typedef struct packed {
        logic shift;
        logic inject;
    } t_cell_ctrl;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] zone;
        logic [2:0]  reason;
    } t_event;

    function automatic logic [DUR_W-1:0] sat_add(input logic [DUR_W-1:0] a,
                                                 input logic [DUR_W-1:0] b);
        logic [DUR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DUR_W] ? {DUR_W{1'b1}} : s[DUR_W-1:0];
    endfunction

endpackage

// File: rtl/core/ztr_cell.sv
// One context cell of the shifting table.
module ztr_cell (
    input  logic                i_clk,
    input  ztr_pkg::t_cell_ctrl i_ctrl,
    input  ztr_pkg::t_entry     i_next,
    input  ztr_pkg::t_entry     i_inj,
    output ztr_pkg::t_entry     o_entry
);
    import ztr_pkg::*;

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.inject) begin
            r_entry <= i_inj;
        end else if (i_ctrl.shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;
endmodule

// File: rtl/core/ztr_proc.sv
// Update unit applied to the context leaving the head cell.
module ztr_proc (
    input  ztr_pkg::t_entry i_entry,
    input  logic [1:0]      i_action,
    input  logic [7:0]      i_tick_period,
    input  logic [15:0]     i_zone,
    input  logic            i_found,
    output ztr_pkg::t_entry o_entry,
    output logic            o_keep,
    output logic            o_ev_valid,
    output logic [2:0]      o_ev_reason,
    output logic            o_match
);
    import ztr_pkg::*;

    logic [DUR_W-1:0] el_n;
    logic             over_hold;
    logic             over_max;
    logic [15:0]      bl_n;
    logic [1:0]       hits_n;

    always_comb begin
        el_n      = sat_add(i_entry.elapsed, {{(DUR_W-8){1'b0}}, i_tick_period});
        over_hold = el_n > i_entry.hold;
        over_max  = el_n > {{(DUR_W-16){1'b0}}, i_entry.max_dur};
        bl_n      = (i_entry.blind_left == 16'd0) ? 16'd0 : i_entry.blind_left - 16'd1;
        hits_n    = (i_entry.hits == HIT_MAX) ? HIT_MAX : i_entry.hits + 2'd1;
        o_match   = (i_entry.zone == i_zone) && !i_found;

        o_entry     = i_entry;
        o_keep      = 1'b1;
        o_ev_valid  = 1'b0;
        o_ev_reason = over_hold ? STOP_ACTION : STOP_TIMEOUT;

        if (i_action == ACT_TICK) begin
            if (!i_entry.blind) begin
                o_entry.elapsed = el_n;
                if (over_hold || over_max) begin
                    o_ev_valid         = 1'b1;
                    o_entry.blind      = 1'b1;
                    o_entry.blind_left = bl_n;
                    o_keep             = bl_n != 16'd0;
                end
            end else begin
                o_entry.blind_left = bl_n;
                o_keep             = bl_n != 16'd0;
            end
        end else if (o_match && !i_entry.blind) begin
            o_entry.hits = hits_n;
            if (hits_n <= HIT_SECOND || i_entry.elapsed > i_entry.prev) begin
                o_entry.prev = i_entry.hold;
                o_entry.hold = sat_add(i_entry.hold, {{(DUR_W-16){1'b0}}, i_entry.augment});
            end
        end
    end
endmodule

// File: rtl/core/zone_trigger_hold_blind_tracker_unit.sv
// Top level: zone trigger hold and blind tracker built on a chain of context cells.
//
// channel   dir  signals                        content
// s_axis    in   tvalid tready tdata tuser     one item; tuser = action
// m_axis    out  tvalid tready tdata tuser tlast one event; tuser = event kind
// cfg       in   i_cfg_valid o_cfg_ready data   tick_period
//
// An item is accepted, then each live context passes in turn through the head
// update unit, then a post step appends or flags (detections only), then a flush
// step emits any pending event; a stop goes straight to the flush.
// A full output register that is not being drained stalls the walk and the flush.
// Reset empties the table at once; the config register returns to 1.
module zone_trigger_hold_blind_tracker_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,  // zone_id, reason_in, trigger_present,
                                       // initial, augmentation, max, blind
    input  logic [1:0]  s_axis_tuser,  // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // zone_out, reason_out
    output logic [1:0]  m_axis_tuser,  // event_kind
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);
    import ztr_pkg::*;

    t_state           r_state, n_state;
    logic [7:0]       r_tick;
    logic [CNT_W-1:0] r_len, r_left;
    logic             r_found;
    logic [1:0]       r_action;
    logic [15:0]      r_zone;
    logic [2:0]       r_reason;
    logic [15:0]      r_init, r_aug, r_max, r_blind;
    logic             r_pvalid;
    t_event           r_pend;
    logic             r_ovalid;
    t_event           r_out;
    logic             r_olast;

    logic   accept, can_push, step, post, fpush, table_full, out_load;
    t_entry cells [MAX_CONTEXTS];
    t_entry proc_entry, new_entry;
    logic   keep, ev_valid, match;
    logic [2:0] ev_reason;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = r_state == ST_IDLE;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign can_push      = !r_ovalid || m_axis_tready;
    assign table_full    = r_len == CNT_W'(MAX_CONTEXTS);
    assign out_load      = (step && ev_valid && r_pvalid) || fpush;

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'd0, r_out.reason, r_out.zone};
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_olast;

    always_comb begin
        new_entry            = '0;
        new_entry.zone       = r_zone;
        new_entry.hold       = {{(DUR_W-16){1'b0}}, r_init};
        new_entry.prev       = {{(DUR_W-16){1'b0}}, r_init};
        new_entry.blind_left = r_blind;
        new_entry.hits       = 2'd1;
        new_entry.max_dur    = r_max;
        new_entry.augment    = r_aug;
    end

    ztr_proc u_proc (
        .i_entry       (cells[0]),
        .i_action      (r_action),
        .i_tick_period (r_tick),
        .i_zone        (r_zone),
        .i_found       (r_found),
        .o_entry       (proc_entry),
        .o_keep        (keep),
        .o_ev_valid    (ev_valid),
        .o_ev_reason   (ev_reason),
        .o_match       (match)
    );

    for (genvar k = 0; k < MAX_CONTEXTS; k++) begin : g_cell
        t_cell_ctrl ctrl;
        t_entry     nxt;
        assign ctrl.shift  = step;
        assign ctrl.inject = step ? (keep && (CNT_W'(k + 1) == r_len))
                                  : (post && !r_found && !table_full && (CNT_W'(k) == r_len));
        if (k < MAX_CONTEXTS - 1) begin : g_mid
            assign nxt = cells[k+1];
        end else begin : g_end
            assign nxt = '0;
        end
        ztr_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (ctrl),
            .i_next  (nxt),
            .i_inj   (step ? proc_entry : new_entry),
            .o_entry (cells[k])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_axis_tuser)
                        ACT_TICK:   n_state = (r_len == '0) ? ST_FLUSH : ST_WALK;
                        ACT_DETECT: n_state = !s_axis_tdata[19] ? ST_IDLE :
                                              (r_len == '0) ? ST_POST : ST_WALK;
                        ACT_STOP:   n_state = ST_FLUSH;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_WALK: begin
                if (step && r_left == CNT_W'(1)) begin
                    n_state = (r_action == ACT_TICK) ? ST_FLUSH : ST_POST;
                end
            end
            ST_POST:  n_state = ST_FLUSH;
            ST_FLUSH: begin
                if (!r_pvalid || can_push) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        step  = (r_state == ST_WALK) && can_push;
        post  = r_state == ST_POST;
        fpush = (r_state == ST_FLUSH) && r_pvalid && can_push;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_tick   <= 8'd1;
            r_len    <= '0;
            r_left   <= '0;
            r_found  <= 1'b0;
            r_pvalid <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_tick <= i_cfg_data;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
                r_out    <= r_pend;
                r_olast  <= fpush;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (accept) begin
                r_action <= s_axis_tuser;
                r_zone   <= s_axis_tdata[15:0];
                r_reason <= s_axis_tdata[18:16];
                r_init   <= s_axis_tdata[35:20];
                r_aug    <= s_axis_tdata[51:36];
                r_max    <= s_axis_tdata[67:52];
                r_blind  <= s_axis_tdata[83:68];
                r_left   <= r_len;
                r_found  <= 1'b0;
                if (s_axis_tuser == ACT_STOP) begin
                    r_pvalid <= 1'b1;
                    r_pend   <= '{kind: EV_STOPPED, zone: s_axis_tdata[15:0],
                                  reason: s_axis_tdata[18:16]};
                end
            end
            if (step) begin
                r_left <= r_left - CNT_W'(1);
                if (match) begin
                    r_found <= 1'b1;
                end
                if (!keep) begin
                    r_len <= r_len - CNT_W'(1);
                end
                if (ev_valid) begin
                    r_pvalid <= 1'b1;
                    r_pend   <= '{kind: EV_STOPPED, zone: cells[0].zone, reason: ev_reason};
                end
            end
            if (post && !r_found) begin
                r_pvalid <= 1'b1;
                if (table_full) begin
                    r_pend <= '{kind: EV_FULL, zone: r_zone, reason: STOP_ACTION};
                end else begin
                    r_len  <= r_len + CNT_W'(1);
                    r_pend <= '{kind: EV_TRIGGERED, zone: r_zone, reason: r_reason};
                end
            end
            if (fpush) begin
                r_pvalid <= 1'b0;
            end
        end
    end

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= CNT_W'(MAX_CONTEXTS))
        else $error("context count beyond table depth");

    a_walk_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_left != '0))
        else $error("walk with no context left");

    a_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pvalid)
        else $error("pending event left behind in idle");

    a_walk_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_left <= r_len))
        else $error("walk count exceeds live contexts");
endmodule

// File: sim/zone_trigger_hold_blind_tracker_unit_chk.sv
`timescale 1ns / 1ps
// Checker: predicts zone tracker events from accepted transfers and compares the output stream.
module zone_trigger_hold_blind_tracker_unit_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    input  logic [1:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    output int          o_fails,
    output int          o_pending
);
    import ztr_pkg::*;

    typedef struct {
        logic [1:0]  kind;
        logic [15:0] zone;
        logic [2:0]  reason;
        logic        last;
    } t_zone_event;

    t_zone_event      event_q[$];
    logic [7:0]       period;
    int               live;
    logic [15:0]      ctx_zone[MAX_CONTEXTS];
    logic             ctx_blind[MAX_CONTEXTS];
    logic [DUR_W-1:0] ctx_hold[MAX_CONTEXTS];
    logic [DUR_W-1:0] ctx_prev[MAX_CONTEXTS];
    logic [DUR_W-1:0] ctx_elapsed[MAX_CONTEXTS];
    logic [15:0]      ctx_blind_left[MAX_CONTEXTS];
    logic [1:0]       ctx_hits[MAX_CONTEXTS];
    logic [15:0]      ctx_max[MAX_CONTEXTS];
    logic [15:0]      ctx_aug[MAX_CONTEXTS];

    function automatic logic [DUR_W-1:0] add_capped(logic [DUR_W-1:0] a, logic [DUR_W-1:0] b);
        logic [DUR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DUR_W] ? {DUR_W{1'b1}} : s[DUR_W-1:0];
    endfunction

    function automatic void push_event(logic [1:0] kind, logic [15:0] zone, logic [2:0] reason);
        t_zone_event e;
        e.kind = kind;
        e.zone = zone;
        e.reason = reason;
        e.last = 1'b0;
        event_q.insert(event_q.size(), e);
    endfunction

    function automatic void free_context(int i);
        for (int k = i; k + 1 < live; k++) begin
            ctx_zone[k]       = ctx_zone[k + 1];
            ctx_blind[k]      = ctx_blind[k + 1];
            ctx_hold[k]       = ctx_hold[k + 1];
            ctx_prev[k]       = ctx_prev[k + 1];
            ctx_elapsed[k]    = ctx_elapsed[k + 1];
            ctx_blind_left[k] = ctx_blind_left[k + 1];
            ctx_hits[k]       = ctx_hits[k + 1];
            ctx_max[k]        = ctx_max[k + 1];
            ctx_aug[k]        = ctx_aug[k + 1];
        end
        live--;
    endfunction

    function automatic void track_item(logic [1:0] act, logic [87:0] d);
        int before_n;
        int i;
        int found;
        logic [15:0] zone;
        logic [2:0]  reason;
        before_n = event_q.size();
        zone = d[15:0];
        reason = d[18:16];
        if (act == ACT_TICK) begin
            i = 0;
            while (i < live) begin
                if (!ctx_blind[i]) begin
                    ctx_elapsed[i] = add_capped(ctx_elapsed[i], {12'd0, period});
                    if (ctx_elapsed[i] > ctx_hold[i] || ctx_elapsed[i] > {4'd0, ctx_max[i]}) begin
                        push_event(EV_STOPPED, ctx_zone[i],
                                   ctx_elapsed[i] > ctx_hold[i] ? STOP_ACTION : STOP_TIMEOUT);
                        ctx_blind[i] = 1'b1;
                    end else begin
                        i++;
                        continue;
                    end
                end
                if (ctx_blind_left[i] != 0) ctx_blind_left[i]--;
                if (ctx_blind_left[i] != 0) i++;
                else free_context(i);
            end
        end else if (act == ACT_DETECT) begin
            if (!d[19]) return;
            found = -1;
            for (int k = 0; k < live; k++) begin
                if (found < 0 && ctx_zone[k] == zone) found = k;
            end
            if (found < 0) begin
                if (live >= MAX_CONTEXTS) begin
                    push_event(EV_FULL, zone, STOP_ACTION);
                end else begin
                    ctx_zone[live]       = zone;
                    ctx_blind[live]      = 1'b0;
                    ctx_hold[live]       = {4'd0, d[35:20]};
                    ctx_prev[live]       = {4'd0, d[35:20]};
                    ctx_elapsed[live]    = '0;
                    ctx_aug[live]        = d[51:36];
                    ctx_max[live]        = d[67:52];
                    ctx_blind_left[live] = d[83:68];
                    ctx_hits[live]       = 2'd1;
                    live++;
                    push_event(EV_TRIGGERED, zone, reason);
                end
            end else if (!ctx_blind[found]) begin
                if (ctx_hits[found] != HIT_MAX) ctx_hits[found]++;
                if (ctx_hits[found] <= HIT_SECOND || ctx_elapsed[found] > ctx_prev[found]) begin
                    ctx_prev[found] = ctx_hold[found];
                    ctx_hold[found] = add_capped(ctx_hold[found], {4'd0, ctx_aug[found]});
                end
            end
        end else if (act == ACT_STOP) begin
            push_event(EV_STOPPED, zone, reason);
        end
        if (event_q.size() > before_n) event_q[event_q.size() - 1].last = 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_zone_event e;
        if (!i_rst_n) begin
            period = 8'd1;
            live = 0;
            event_q.delete();
            o_fails <= 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) period = i_cfg_data;
            if (s_axis_tvalid && s_axis_tready) track_item(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                if (event_q.size() == 0) begin
                    if (o_fails < 10)
                        $display("unexpected transfer: kind %0d zone %h reason %0d last %0b",
                                 m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[18:16],
                                 m_axis_tlast);
                    o_fails <= o_fails + 1;
                end else begin
                    e = event_q.pop_front();
                    if (e.kind !== m_axis_tuser || e.zone !== m_axis_tdata[15:0] ||
                        e.reason !== m_axis_tdata[18:16] || e.last !== m_axis_tlast) begin
                        if (o_fails < 10)
                            $display("exp kind %0d zone %h reason %0d last %0b, got %0d %h %0d %0b",
                                     e.kind, e.zone, e.reason, e.last, m_axis_tuser,
                                     m_axis_tdata[15:0], m_axis_tdata[18:16], m_axis_tlast);
                        o_fails <= o_fails + 1;
                    end
                end
            end
        end
        o_pending = event_q.size();
    end

endmodule

// File: sim/zone_trigger_hold_blind_tracker_unit_test.sv
`timescale 1ns / 1ps
// Testbench top: drives items and config writes into the zone tracker and reports the verdict.
module zone_trigger_hold_blind_tracker_unit_test;
    import ztr_pkg::*;

    localparam int IDLE_LIMIT = 4000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = ACT_TICK;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data = 8'd1;
    int          fails;
    int          pending;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          quiet_cycles = 0;

    always #4 i_clk = ~i_clk;

    zone_trigger_hold_blind_tracker_unit DUT (.*);

    zone_trigger_hold_blind_tracker_unit_chk u_chk (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_data,
        .o_fails(fails), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send(logic [1:0] act, logic [15:0] zone, logic [2:0] reason, logic present,
                        logic [15:0] init, logic [15:0] aug, logic [15:0] max_d,
                        logic [15:0] blind);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {4'd0, blind, max_d, aug, init, present, reason, zone};
        forever begin
            @(negedge i_clk);
            if (s_axis_tready) break;
        end
        @(posedge i_clk);
    endtask

    task automatic drain_and_write(logic [7:0] value);
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        forever begin
            @(negedge i_clk);
            if (o_cfg_ready) break;
        end
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_random();
        int r;
        logic [15:0] zone, init, aug, max_d, blind;
        r = $urandom_range(99);
        zone  = ($urandom_range(9) == 0) ? 16'($urandom) : 16'h0100 + 16'($urandom_range(11));
        init  = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(12));
        aug   = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(10));
        max_d = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(30));
        blind = ($urandom_range(29) == 0) ? 16'($urandom) : 16'($urandom_range(4));
        send(r < 45 ? ACT_TICK : r < 88 ? ACT_DETECT : r < 96 ? ACT_STOP : ACT_NONE,
             zone, 3'($urandom), $urandom_range(9) != 0, init, aug, max_d, blind);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(ACT_TICK, 16'h0000, 3'd0, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0);
        send(ACT_DETECT, 16'h0000, 3'd7, 1'b0, 16'd5, 16'd5, 16'd5, 16'd5);
        send(ACT_DETECT, 16'h0000, 3'd7, 1'b1, 16'd5, 16'hFFFF, 16'hFFFF, 16'd2);
        send(ACT_DETECT, 16'h0000, 3'd1, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0);
        send(ACT_STOP, 16'hFFFF, 3'd7, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send(ACT_NONE, 16'h1234, 3'd5, 1'b1, 16'd1, 16'd1, 16'd1, 16'd1);
        send(ACT_DETECT, 16'hFFFF, 3'd2, 1'b1, 16'hFFFF, 16'd0, 16'd0, 16'd0);
        for (int z = 1; z <= 6; z++)
            send(ACT_DETECT, 16'(z), 3'(z), 1'b1, 16'(z - 1), 16'd3, 16'(z + 2), 16'(z % 3));
        send(ACT_DETECT, 16'h0007, 3'd4, 1'b1, 16'd1, 16'd1, 16'd1, 16'd1);
        send(ACT_DETECT, 16'h0000, 3'd0, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0);
        repeat (8) send(ACT_TICK, 16'h0000, 3'd0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0);
        send(ACT_DETECT, 16'hFFFF, 3'd3, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0);

        for (int ph = 0; ph < 4; ph++) begin
            drain_and_write(ph == 0 ? 8'd1 : ph == 1 ? 8'd255 : ph == 2 ? 8'($urandom) : 8'd2);
            send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 81 : 34) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 81 : 34) : 0;
            repeat (100) send_random();
        end

        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (40) @(posedge i_clk);
        if (fails == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: zone_trigger_hold_blind_tracker_unit.f
rtl/core/ztr_pkg.sv
rtl/core/ztr_cell.sv
rtl/core/ztr_proc.sv
rtl/core/zone_trigger_hold_blind_tracker_unit.sv
sim/zone_trigger_hold_blind_tracker_unit_chk.sv
sim/zone_trigger_hold_blind_tracker_unit_test.sv
